// ----- sv/stq_pkg.sv -----
`timescale 1ns / 1ps

package stq_pkg;

    localparam int NUM_TIMERS_DEF = 32;
    localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

    typedef enum logic [2:0] {
        FUNC_TICK  = 3'd0,
        FUNC_ALLOC = 3'd1,
        FUNC_FREE  = 3'd2,
        FUNC_BIND  = 3'd3,
        FUNC_ARM   = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_ALLOC,
        OP_FREE,
        OP_BIND,
        OP_ARM,
        OP_BAD
    } t_op;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FIRE  = 2'd1,
        KIND_ACK   = 2'd2,
        KIND_ERR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_UNUSED = 2'd0,
        ST_ALLOC  = 2'd1,
        ST_ARMED  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_TK_RD,
        S_TK_CHK,
        S_AR_RD,
        S_AR_HEAD,
        S_AR_CHK,
        S_AR_L1,
        S_AR_L2
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [4:0]         timer_id;
        logic [31:0]        delay;
        logic [7:0]         queue_id;
        logic signed [31:0] payload;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        logic [4:0]         slot;
        logic [7:0]         dest_queue;
        logic signed [31:0] fire_value;
        logic               last;
    } t_res;

endpackage

// ----- sv/stq_front.sv -----
`timescale 1ns / 1ps

module stq_front #(
    parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_func,
    input  logic [4:0]         i_timer_id,
    input  logic [31:0]        i_delay,
    input  logic [7:0]         i_queue_id,
    input  logic signed [31:0] i_payload,
    output logic               o_cmd_valid,
    output stq_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_pop
);

    stq_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    stq_pkg::t_cmd cls;
    logic          id_bad;
    logic          wr, rd;

    // classify the request before it is queued
    always_comb begin
        id_bad       = {2'b00, i_timer_id} >= 7'(NUM_TIMERS);
        cls.timer_id = i_timer_id;
        cls.delay    = i_delay;
        cls.queue_id = i_queue_id;
        cls.payload  = i_payload;
        case (stq_pkg::t_func'(i_func))
            stq_pkg::FUNC_TICK:  cls.op = stq_pkg::OP_TICK;
            stq_pkg::FUNC_ALLOC: cls.op = stq_pkg::OP_ALLOC;
            stq_pkg::FUNC_FREE:  cls.op = id_bad ? stq_pkg::OP_BAD : stq_pkg::OP_FREE;
            stq_pkg::FUNC_BIND:  cls.op = id_bad ? stq_pkg::OP_BAD : stq_pkg::OP_BIND;
            stq_pkg::FUNC_ARM:   cls.op = id_bad ? stq_pkg::OP_BAD : stq_pkg::OP_ARM;
            default:             cls.op = stq_pkg::OP_BAD;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = push && !full;
    assign rd          = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= cls;
    end

endmodule

// ----- sv/stq_outq.sv -----
`timescale 1ns / 1ps

module stq_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_push,
    input  stq_pkg::t_res      i_res,
    output logic               o_res_full,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_kind,
    output logic [4:0]         o_slot,
    output logic [7:0]         o_dest_queue,
    output logic signed [31:0] o_fire_value,
    output logic               o_last
);

    stq_pkg::t_res r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          wr, rd;
    stq_pkg::t_res head;

    assign o_res_full   = (r_cnt == 2'd2);
    assign empty        = (r_cnt == 2'd0);
    assign wr           = i_res_push && !o_res_full;
    assign rd           = pop && !empty;
    assign head         = r_q[r_rp];
    assign o_kind       = head.kind;
    assign o_slot       = head.slot;
    assign o_dest_queue = head.dest_queue;
    assign o_fire_value = head.fire_value;
    assign o_last       = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= i_res;
    end

endmodule

// ----- sv/stq_back.sv -----
`timescale 1ns / 1ps

module stq_back #(
    parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  stq_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_res_push,
    output stq_pkg::t_res o_res,
    input  logic          i_res_full
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);

    stq_pkg::t_state r_state, n_state;
    stq_pkg::t_cmd   r_cmd, n_cmd;
    logic [31:0]     r_tick, n_tick;
    logic [31:0]     r_nd, n_nd;
    logic [CW-1:0]   r_active, n_active;
    logic [IW-1:0]   r_head, n_head;
    logic [IW-1:0]   r_t, n_t;
    logic [IW-1:0]   r_s, n_s;
    logic [CW-1:0]   r_i, n_i;
    logic [31:0]     r_dl, n_dl;
    logic [IW-1:0]   r_lnk_val, n_lnk_val;
    logic            r_pend_vld, n_pend_vld;
    stq_pkg::t_res   r_pend, n_pend;
    stq_pkg::t_status r_status [NUM_TIMERS];

    // slot stores, undefined until written
    logic [31:0]        m_dl  [NUM_TIMERS];
    logic [IW-1:0]      m_lnk [NUM_TIMERS];
    logic [7:0]         m_q   [NUM_TIMERS];
    logic signed [31:0] m_v   [NUM_TIMERS];
    logic [31:0]        r_dl_q;
    logic [IW-1:0]      r_lnk_q;
    logic [7:0]         r_q_q;
    logic signed [31:0] r_v_q;

    logic [IW-1:0] rd_addr;
    logic          dl_we, lnk_we, qv_we;
    logic [IW-1:0] dl_wa, lnk_wa;
    logic [31:0]   dl_wd;
    logic [IW-1:0] lnk_wd;

    logic          st_we;
    logic [IW-1:0] st_wa;
    stq_pkg::t_status st_wd;

    logic [6:0]    id_w;
    logic [IW-1:0] id_ix;
    logic          free_found;
    logic [IW-1:0] free_ix;
    logic [6:0]    free_w, t_w;
    logic [31:0]   tick_inc, arm_dl;
    logic [CW-1:0] act_left;
    logic          fire;

    assign id_w     = {2'b00, r_cmd.timer_id};
    assign id_ix    = id_w[IW-1:0];
    assign tick_inc = r_tick + 32'd1;
    assign arm_dl   = r_tick + r_cmd.delay;
    assign act_left = r_active - r_i;
    assign free_w   = 7'(free_ix);
    assign t_w      = 7'(r_t);
    assign fire     = (r_i < r_active) && !(r_dl_q > r_tick);

    // lowest unused slot
    always_comb begin
        free_found = 1'b0;
        free_ix    = '0;
        for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
            if (r_status[k] == stq_pkg::ST_UNUSED) begin
                free_found = 1'b1;
                free_ix    = IW'(k);
            end
        end
    end

    function automatic stq_pkg::t_res mk_res(stq_pkg::t_kind kind, logic [4:0] slot);
        stq_pkg::t_res r;
        r.kind       = kind;
        r.slot       = slot;
        r.dest_queue = 8'd0;
        r.fire_value = 32'sd0;
        r.last       = 1'b1;
        return r;
    endfunction

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_tick     = r_tick;
        n_nd       = r_nd;
        n_active   = r_active;
        n_head     = r_head;
        n_t        = r_t;
        n_s        = r_s;
        n_i        = r_i;
        n_dl       = r_dl;
        n_lnk_val  = r_lnk_val;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = mk_res(stq_pkg::KIND_ACK, 5'd0);
        rd_addr    = r_t;
        dl_we      = 1'b0;
        dl_wa      = id_ix;
        dl_wd      = arm_dl;
        lnk_we     = 1'b0;
        lnk_wa     = id_ix;
        lnk_wd     = '0;
        qv_we      = 1'b0;
        st_we      = 1'b0;
        st_wa      = id_ix;
        st_wd      = stq_pkg::ST_ALLOC;

        case (r_state)
            stq_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = stq_pkg::S_EXEC;
                end
            end
            stq_pkg::S_EXEC: begin
                if (!i_res_full) begin
                    n_state = stq_pkg::S_IDLE;
                    case (r_cmd.op)
                        stq_pkg::OP_TICK: begin
                            n_tick = tick_inc;
                            if (r_nd > tick_inc) begin
                                o_res_push = 1'b1;
                            end else begin
                                n_t        = r_head;
                                n_i        = '0;
                                n_pend_vld = 1'b0;
                                n_state    = stq_pkg::S_TK_RD;
                            end
                        end
                        stq_pkg::OP_ALLOC: begin
                            o_res_push = 1'b1;
                            if (free_found) begin
                                st_we = 1'b1;
                                st_wa = free_ix;
                                o_res = mk_res(stq_pkg::KIND_ALLOC, free_w[4:0]);
                            end else begin
                                o_res = mk_res(stq_pkg::KIND_ERR, 5'd0);
                            end
                        end
                        stq_pkg::OP_FREE: begin
                            o_res_push = 1'b1;
                            if (r_status[id_ix] == stq_pkg::ST_ARMED) begin
                                o_res = mk_res(stq_pkg::KIND_ERR, 5'd0);
                            end else begin
                                st_we = 1'b1;
                                st_wd = stq_pkg::ST_UNUSED;
                            end
                        end
                        stq_pkg::OP_BIND: begin
                            o_res_push = 1'b1;
                            qv_we      = 1'b1;
                        end
                        stq_pkg::OP_ARM: begin
                            if (r_status[id_ix] == stq_pkg::ST_ARMED) begin
                                o_res_push = 1'b1;
                                o_res      = mk_res(stq_pkg::KIND_ERR, 5'd0);
                            end else begin
                                dl_we = 1'b1;
                                st_we = 1'b1;
                                st_wd = stq_pkg::ST_ARMED;
                                n_dl  = arm_dl;
                                if (r_active == '0) begin
                                    lnk_we     = 1'b1;
                                    n_head     = id_ix;
                                    n_nd       = arm_dl;
                                    n_active   = CW'(1);
                                    o_res_push = 1'b1;
                                end else if (!(arm_dl > r_nd)) begin
                                    // ties go ahead of the older entry
                                    lnk_we     = 1'b1;
                                    lnk_wd     = r_head;
                                    n_head     = id_ix;
                                    n_nd       = arm_dl;
                                    n_active   = r_active + CW'(1);
                                    o_res_push = 1'b1;
                                end else begin
                                    n_state = stq_pkg::S_AR_RD;
                                end
                            end
                        end
                        default: begin
                            o_res_push = 1'b1;
                            o_res      = mk_res(stq_pkg::KIND_ERR, 5'd0);
                        end
                    endcase
                end
            end
            stq_pkg::S_TK_RD: begin
                rd_addr = r_t;
                n_state = stq_pkg::S_TK_CHK;
            end
            stq_pkg::S_TK_CHK: begin
                if (fire) begin
                    // hold each firing until the next check tells whether it is the last
                    if (!(r_pend_vld && i_res_full)) begin
                        if (r_pend_vld) begin
                            o_res_push = 1'b1;
                            o_res      = r_pend;
                            o_res.last = 1'b0;
                        end
                        n_pend.kind       = stq_pkg::KIND_FIRE;
                        n_pend.slot       = t_w[4:0];
                        n_pend.dest_queue = r_q_q;
                        n_pend.fire_value = r_v_q;
                        n_pend.last       = 1'b1;
                        n_pend_vld        = 1'b1;
                        st_we   = 1'b1;
                        st_wa   = r_t;
                        n_i     = r_i + CW'(1);
                        n_t     = r_lnk_q;
                        n_state = stq_pkg::S_TK_RD;
                    end
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_pend_vld) o_res = r_pend;
                    n_active = act_left;
                    n_head   = r_t;
                    n_nd     = (act_left != '0) ? r_dl_q : stq_pkg::NO_DEADLINE;
                    n_state  = stq_pkg::S_IDLE;
                end
            end
            stq_pkg::S_AR_RD: begin
                rd_addr = r_head;
                n_s     = r_head;
                n_i     = CW'(1);
                n_state = stq_pkg::S_AR_HEAD;
            end
            stq_pkg::S_AR_HEAD: begin
                if (r_i < r_active) begin
                    rd_addr = r_lnk_q;
                    n_t     = r_lnk_q;
                    n_state = stq_pkg::S_AR_CHK;
                end else begin
                    n_lnk_val = '0;
                    n_state   = stq_pkg::S_AR_L1;
                end
            end
            stq_pkg::S_AR_CHK: begin
                if (!(r_dl > r_dl_q)) begin
                    n_lnk_val = r_t;
                    n_state   = stq_pkg::S_AR_L1;
                end else begin
                    n_s = r_t;
                    n_i = r_i + CW'(1);
                    if ((r_i + CW'(1)) < r_active) begin
                        rd_addr = r_lnk_q;
                        n_t     = r_lnk_q;
                    end else begin
                        n_lnk_val = '0;
                        n_state   = stq_pkg::S_AR_L1;
                    end
                end
            end
            stq_pkg::S_AR_L1: begin
                lnk_we  = 1'b1;
                lnk_wa  = r_s;
                lnk_wd  = id_ix;
                n_state = stq_pkg::S_AR_L2;
            end
            stq_pkg::S_AR_L2: begin
                lnk_we = 1'b1;
                lnk_wd = r_lnk_val;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_active   = r_active + CW'(1);
                    n_state    = stq_pkg::S_IDLE;
                end
            end
            default: n_state = stq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= stq_pkg::S_IDLE;
            r_tick     <= '0;
            r_nd       <= stq_pkg::NO_DEADLINE;
            r_active   <= '0;
            r_head     <= '0;
            r_pend_vld <= 1'b0;
            for (int k = 0; k < NUM_TIMERS; k++) r_status[k] <= stq_pkg::ST_UNUSED;
        end else begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_nd       <= n_nd;
            r_active   <= n_active;
            r_head     <= n_head;
            r_pend_vld <= n_pend_vld;
            if (st_we) r_status[st_wa] <= st_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_t       <= n_t;
        r_s       <= n_s;
        r_i       <= n_i;
        r_dl      <= n_dl;
        r_lnk_val <= n_lnk_val;
        r_pend    <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (dl_we) m_dl[dl_wa] <= dl_wd;
        if (lnk_we) m_lnk[lnk_wa] <= lnk_wd;
        if (qv_we) begin
            m_q[id_ix] <= r_cmd.queue_id;
            m_v[id_ix] <= r_cmd.payload;
        end
        r_dl_q  <= m_dl[rd_addr];
        r_lnk_q <= m_lnk[rd_addr];
        r_q_q   <= m_q[rd_addr];
        r_v_q   <= m_v[rd_addr];
    end

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= CW'(NUM_TIMERS))
        else $error("armed count exceeds pool size");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stq_pkg::S_TK_CHK) |-> (r_i <= r_active))
        else $error("expiry walk ran past armed count");

    a_arm_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stq_pkg::S_AR_CHK) |-> (r_active != '0))
        else $error("sorted insert walk on empty list");

endmodule

// ----- sv/sorted_timer_queue_core.sv -----
`timescale 1ns / 1ps

// channel   handshake            fields
// request   push / full          i_func, i_timer_id, i_delay, i_queue_id, i_payload
// result    empty / pop          o_kind, o_slot, o_dest_queue, o_fire_value, o_last
//
// Allocate, free, bind and error requests are handled in the execute state.
// Arm links at the list head directly, else walks the entries after the head.
// A tick without expiry only acks; else it walks the list firing expired timers.
// Reset clears all slot status at once; no clearing pass.
// A two-entry request queue and a two-entry result queue decouple both sides.

module sorted_timer_queue_core #(
    parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_func,
    input  logic [4:0]         i_timer_id,
    input  logic [31:0]        i_delay,
    input  logic [7:0]         i_queue_id,
    input  logic signed [31:0] i_payload,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_kind,
    output logic [4:0]         o_slot,
    output logic [7:0]         o_dest_queue,
    output logic signed [31:0] o_fire_value,
    output logic               o_last
);

    logic          cmd_valid, cmd_pop;
    stq_pkg::t_cmd cmd;
    logic          res_push, res_full;
    stq_pkg::t_res res;

    stq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_func     (i_func),
        .i_timer_id (i_timer_id),
        .i_delay    (i_delay),
        .i_queue_id (i_queue_id),
        .i_payload  (i_payload),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    stq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_res_push (res_push),
        .o_res      (res),
        .i_res_full (res_full)
    );

    stq_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_push  (res_push),
        .i_res       (res),
        .o_res_full  (res_full),
        .empty       (empty),
        .pop         (pop),
        .o_kind      (o_kind),
        .o_slot      (o_slot),
        .o_dest_queue(o_dest_queue),
        .o_fire_value(o_fire_value),
        .o_last      (o_last)
    );

endmodule

// ----- tb/tb_sorted_timer_queue_core.sv -----
`timescale 1ns / 1ps

module tb_sorted_timer_queue_core;

    localparam int NT = stq_pkg::NUM_TIMERS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]  kind;
        logic [4:0]  slot;
        logic [7:0]  dest_queue;
        logic [31:0] fire_value;
        logic        last;
    } t_fire_rec;

    class timer_scoreboard;
        logic [31:0]      tick_count;
        logic [31:0]      next_deadline;
        int               active_count;
        int               head_slot;
        stq_pkg::t_status status[NT];
        logic [31:0]      deadline[NT];
        logic [7:0]       queue_of[NT];
        logic [31:0]      value_of[NT];
        int               link[NT];
        t_fire_rec        pending[$];
        int               errors;
        int               results_seen;

        function new();
            tick_count = '0;
            next_deadline = stq_pkg::NO_DEADLINE;
            active_count = 0;
            head_slot = 0;
            errors = 0;
            results_seen = 0;
            foreach (status[i]) begin
                status[i] = stq_pkg::ST_UNUSED;
                deadline[i] = '0;
                queue_of[i] = '0;
                value_of[i] = '0;
                link[i] = 0;
            end
        endfunction

        function void push_res(logic [1:0] k, int s, logic [7:0] q, logic [31:0] v,
                               logic l);
            t_fire_rec r;
            r.kind = k;
            r.slot = s[4:0];
            r.dest_queue = q;
            r.fire_value = v;
            r.last = l;
            pending.push_back(r);
        endfunction

        function void link_by_deadline(int id);
            logic [31:0] d;
            int s;
            int t;
            bit placed;
            d = deadline[id];
            placed = 0;
            if (active_count == 0) begin
                head_slot = id;
                link[id] = 0;
                next_deadline = d;
            end else if (d <= deadline[head_slot]) begin
                link[id] = head_slot;
                head_slot = id;
                next_deadline = d;
            end else begin
                s = head_slot;
                for (int k = 1; k < active_count && !placed; k++) begin
                    t = link[s];
                    if (d <= deadline[t]) begin
                        link[s] = id;
                        link[id] = t;
                        placed = 1;
                    end else begin
                        s = t;
                    end
                end
                if (!placed) begin
                    link[s] = id;
                    link[id] = 0;
                end
            end
            active_count++;
        endfunction

        function void note_request(logic [2:0] fn, logic [4:0] id, logic [31:0] dly,
                                   logic [7:0] q, logic [31:0] v);
            int t;
            int n;
            bit done;
            case (fn)
                stq_pkg::FUNC_TICK: begin
                    tick_count++;
                    if (next_deadline > tick_count) begin
                        push_res(stq_pkg::KIND_ACK, 0, 0, 0, 1);
                    end else begin
                        t = head_slot;
                        n = 0;
                        done = 0;
                        while (n < active_count && !done) begin
                            if (deadline[t] > tick_count) begin
                                done = 1;
                            end else begin
                                status[t] = stq_pkg::ST_ALLOC;
                                push_res(stq_pkg::KIND_FIRE, t, queue_of[t], value_of[t], 0);
                                n++;
                                t = link[t];
                            end
                        end
                        active_count -= n;
                        head_slot = t;
                        next_deadline = (active_count > 0) ? deadline[t]
                                                           : stq_pkg::NO_DEADLINE;
                        if (n == 0) push_res(stq_pkg::KIND_ACK, 0, 0, 0, 1);
                        else pending[$].last = 1;
                    end
                end
                stq_pkg::FUNC_ALLOC: begin
                    done = 0;
                    for (int i = 0; i < NT && !done; i++) begin
                        if (status[i] == stq_pkg::ST_UNUSED) begin
                            status[i] = stq_pkg::ST_ALLOC;
                            push_res(stq_pkg::KIND_ALLOC, i, 0, 0, 1);
                            done = 1;
                        end
                    end
                    if (!done) push_res(stq_pkg::KIND_ERR, 0, 0, 0, 1);
                end
                stq_pkg::FUNC_FREE: begin
                    if (status[id] == stq_pkg::ST_ARMED) begin
                        push_res(stq_pkg::KIND_ERR, 0, 0, 0, 1);
                    end else begin
                        status[id] = stq_pkg::ST_UNUSED;
                        push_res(stq_pkg::KIND_ACK, 0, 0, 0, 1);
                    end
                end
                stq_pkg::FUNC_BIND: begin
                    queue_of[id] = q;
                    value_of[id] = v;
                    push_res(stq_pkg::KIND_ACK, 0, 0, 0, 1);
                end
                stq_pkg::FUNC_ARM: begin
                    if (status[id] == stq_pkg::ST_ARMED) begin
                        push_res(stq_pkg::KIND_ERR, 0, 0, 0, 1);
                    end else begin
                        deadline[id] = tick_count + dly;
                        status[id] = stq_pkg::ST_ARMED;
                        link_by_deadline(id);
                        push_res(stq_pkg::KIND_ACK, 0, 0, 0, 1);
                    end
                end
                default: push_res(stq_pkg::KIND_ERR, 0, 0, 0, 1);
            endcase
        endfunction

        function void check_result(logic [1:0] k, logic [4:0] s, logic [7:0] q,
                                   logic [31:0] v, logic l);
            t_fire_rec e;
            results_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result kind=%0d slot=%0d", k, s);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind) begin
                $error("kind: expected %0d, actual %0d", e.kind, k); errors++;
            end
            if (s !== e.slot) begin
                $error("slot: expected %0d, actual %0d", e.slot, s); errors++;
            end
            if (q !== e.dest_queue) begin
                $error("dest_queue: expected %0d, actual %0d", e.dest_queue, q);
                errors++;
            end
            if (v !== e.fire_value) begin
                $error("fire_value: expected %h, actual %h", e.fire_value, v);
                errors++;
            end
            if (l !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, l); errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [2:0]         i_func;
    logic [4:0]         i_timer_id;
    logic [31:0]        i_delay;
    logic [7:0]         i_queue_id;
    logic signed [31:0] i_payload;
    logic               empty;
    logic               pop;
    logic [1:0]         o_kind;
    logic [4:0]         o_slot;
    logic [7:0]         o_dest_queue;
    logic signed [31:0] o_fire_value;
    logic               o_last;

    sorted_timer_queue_core dut (.*);

    timer_scoreboard sb;
    int  cycles;
    int  push_idle_pct;
    int  pop_idle_pct;
    int  requests_sent;
    int  fires_seen;
    bit  drained;
    // slots that have had a bind since reset; only these may be armed
    bit  bound[NT];

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_func = '0;
        i_timer_id = '0;
        i_delay = '0;
        i_queue_id = '0;
        i_payload = '0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // check and retire results on the edge they are accepted
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (o_kind == stq_pkg::KIND_FIRE) fires_seen++;
            sb.check_result(o_kind, o_slot, o_dest_queue, o_fire_value, o_last);
        end
        pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    // push stays high after an accept; the next request or an idle cycle drives it
    task automatic send_request(logic [2:0] fn, logic [4:0] id, logic [31:0] dly,
                                logic [7:0] q, logic [31:0] v);
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_func <= fn;
        i_timer_id <= id;
        i_delay <= dly;
        i_queue_id <= q;
        i_payload <= v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(fn, id, dly, q, v);
        requests_sent++;
        if (fn == stq_pkg::FUNC_BIND) bound[id] = 1;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // arm only bound slots so a fire never reads an unwritten entry
    task automatic random_request();
        int r;
        logic [4:0] id;
        logic [31:0] dly;
        r = $urandom_range(99);
        id = 5'($urandom_range(NT - 1));
        dly = ($urandom_range(9) == 0) ? $urandom : $urandom_range(12);
        if (r < 25) send_request(stq_pkg::FUNC_TICK, 5'($urandom), $urandom,
                                 8'($urandom), $urandom);
        else if (r < 40) send_request(stq_pkg::FUNC_ALLOC, 5'($urandom), $urandom,
                                      8'($urandom), $urandom);
        else if (r < 50) send_request(stq_pkg::FUNC_FREE, id, $urandom, 8'($urandom),
                                      $urandom);
        else if (r < 68) send_request(stq_pkg::FUNC_BIND, id, $urandom, 8'($urandom),
                                      $urandom);
        else if (r < 95) begin
            if (!bound[id]) send_request(stq_pkg::FUNC_BIND, id, $urandom, 8'($urandom),
                                         $urandom);
            send_request(stq_pkg::FUNC_ARM, id, dly, 8'($urandom), $urandom);
        end else send_request(3'($urandom_range(7, 5)), id, $urandom, 8'($urandom),
                              $urandom);
    endtask

    initial begin
        cycles = 0;
        requests_sent = 0;
        fires_seen = 0;
        push_idle_pct = 21;
        pop_idle_pct = 59;
        sb = new();
        foreach (bound[i]) bound[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty tick, bad funcs, tie ordering, wrap, pool exhaustion
        send_request(stq_pkg::FUNC_TICK, 0, 0, 0, 0);
        send_request(3'd5, 31, 32'hffff_ffff, 8'hff, 32'h8000_0000);
        send_request(3'd7, 0, 0, 0, 0);
        send_request(stq_pkg::FUNC_ALLOC, 0, 0, 0, 0);
        send_request(stq_pkg::FUNC_ALLOC, 0, 0, 0, 0);
        send_request(stq_pkg::FUNC_BIND, 0, 0, 8'hff, 32'h7fff_ffff);
        send_request(stq_pkg::FUNC_BIND, 1, 0, 8'h00, 32'h8000_0000);
        send_request(stq_pkg::FUNC_BIND, 31, 0, 8'ha5, 32'hffff_ffff);
        send_request(stq_pkg::FUNC_ARM, 0, 2, 0, 0);
        send_request(stq_pkg::FUNC_ARM, 1, 2, 0, 0);
        send_request(stq_pkg::FUNC_ARM, 31, 0, 0, 0);
        send_request(stq_pkg::FUNC_ARM, 1, 5, 0, 0);
        send_request(stq_pkg::FUNC_FREE, 1, 0, 0, 0);
        send_request(stq_pkg::FUNC_BIND, 1, 0, 8'h5a, 32'h1234_5678);
        send_request(stq_pkg::FUNC_TICK, 0, 0, 0, 0);
        send_request(stq_pkg::FUNC_TICK, 0, 0, 0, 0);
        send_request(stq_pkg::FUNC_FREE, 0, 0, 0, 0);
        send_request(stq_pkg::FUNC_FREE, 5, 0, 0, 0);
        send_request(stq_pkg::FUNC_ARM, 31, 32'hffff_ffff, 0, 0);
        for (int i = 0; i < NT + 1; i++) send_request(stq_pkg::FUNC_ALLOC, 0, 0, 0, 0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            push_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 59 : 0;
            pop_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 21 : 0;
            for (int n = 0; n < 85; n++) begin
                random_request();
                if (n == 40) wait_drained();
            end
            // free each slot not armed with even odds so allocate keeps finding slots
            for (int i = 0; i < NT; i++) begin
                if ($urandom_range(1) == 0 && sb.status[i] != stq_pkg::ST_ARMED)
                    send_request(stq_pkg::FUNC_FREE, 5'(i), 0, 0, 0);
            end
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d requests, checked %0d results including %0d timer expiries.",
                 requests_sent, sb.results_seen, fires_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
